@@ rtl/spq_pkg.sv @@
// Shared types and codes of the sorted priority queue.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_unit; no dependencies.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;

    // Operation codes on cmd
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_RD,
        ST_REM_LD,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // take the input item, decide status
        logic rd_prev;   // read entry before the insert slot
        logic rd_head;   // read the new head after a remove
        logic shift_wr;  // move the read entry one slot toward the tail
        logic ins_wr;    // write the pending entry into the insert slot
        logic head_ld;   // load the head copy from read data
        logic out_ld;    // load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_ins;    // input item is an insert
        logic full;
        logic empty;
        logic idx_zero;  // insert slot is at the head
        logic prio_gt;   // read entry is less urgent than the pending one
    } dp_stat_t;

endpackage

@@ rtl/spq_dp.sv @@
// Datapath of the sorted priority queue: entry memory (circular), pointers,
// head copy, pending entry and result register. Depends on spq_pkg.
module spq_dp
    import spq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             dcmd,
    output dp_stat_t            dstat,
    input  logic                cmd,
    input  logic [DATA_W-1:0]   data_in,
    input  logic [PRIO_W-1:0]   prio_in,
    output status_t             res_status,
    output entry_t              res_removed,
    output entry_t              res_head,
    output logic [CW-1:0]       res_count
);

    localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Entry memory, one write and one registered read per cycle
    entry_t mem [DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_ptr_reg, head_ptr_next;
    logic [CW-1:0] idx_reg, idx_next;
    entry_t        pend_reg, head_reg, rd_reg, rem_reg;
    status_t       status_reg;
    status_t       out_status_reg;
    entry_t        out_rem_reg, out_head_reg;
    logic [CW-1:0] out_count_reg;

    logic [AW-1:0] wr_addr, rd_addr;
    logic          full, empty;

    // Logical slot to memory address, wrapping at DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] slot);
        logic [AW:0] sum;
        sum = (AW + 1)'(base) + (AW + 1)'(slot);
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    assign dstat.is_ins   = (cmd == CMD_INSERT);
    assign dstat.full     = full;
    assign dstat.empty    = empty;
    assign dstat.idx_zero = (idx_reg == '0);
    assign dstat.prio_gt  = ($signed(rd_reg.prio) > $signed(pend_reg.prio));

    assign wr_addr = dcmd.shift_wr || dcmd.ins_wr ? phys(head_ptr_reg, idx_reg) : '0;
    assign rd_addr = dcmd.rd_prev ? phys(head_ptr_reg, idx_reg - 1'b1) : head_ptr_reg;

    // Memory write: shifted entry or the new entry into the current slot
    always_ff @(posedge clk)
    begin
        if (dcmd.shift_wr)
        begin
            mem[wr_addr] <= rd_reg;
        end
        else if (dcmd.ins_wr)
        begin
            mem[wr_addr] <= pend_reg;
        end
    end

    // Memory read
    always_ff @(posedge clk)
    begin
        if (dcmd.rd_prev || dcmd.rd_head)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Pointer and count updates
    always_comb
    begin
        count_next    = count_reg;
        head_ptr_next = head_ptr_reg;
        idx_next      = idx_reg;
        if (dcmd.accept)
        begin
            if (cmd == CMD_INSERT)
            begin
                idx_next = count_reg;
            end
            else if (!empty)
            begin
                head_ptr_next = phys(head_ptr_reg, CW'(1));
                count_next    = count_reg - 1'b1;
            end
        end
        if (dcmd.shift_wr)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (dcmd.ins_wr)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            head_ptr_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            head_ptr_reg <= head_ptr_next;
            idx_reg      <= idx_next;
        end
    end

    // Item capture, head copy and status
    always_ff @(posedge clk)
    begin
        if (dcmd.accept)
        begin
            pend_reg.data <= data_in;
            pend_reg.prio <= prio_in;
            if (cmd == CMD_INSERT)
            begin
                rem_reg <= '0;
                if (full)
                begin
                    status_reg <= STAT_FULL;
                end
                else
                begin
                    status_reg <= STAT_OK;
                end
            end
            else if (empty)
            begin
                rem_reg    <= '0;
                status_reg <= STAT_EMPTY;
            end
            else
            begin
                rem_reg    <= head_reg;
                status_reg <= STAT_OK;
            end
        end
        if (dcmd.ins_wr && idx_reg == '0)
        begin
            head_reg <= pend_reg;
        end
        else if (dcmd.head_ld)
        begin
            head_reg <= rd_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (dcmd.out_ld)
        begin
            out_status_reg <= status_reg;
            out_rem_reg    <= rem_reg;
            out_head_reg   <= empty ? '0 : head_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign res_status  = out_status_reg;
    assign res_removed = out_rem_reg;
    assign res_head    = out_head_reg;
    assign res_count   = out_count_reg;

endmodule

@@ rtl/spq_ctrl.sv @@
// Controller of the sorted priority queue: sequences insert shifts, head
// reloads and result hand-off. Depends on spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t dstat,
    output dp_cmd_t  dcmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (dstat.is_ins)
                    begin
                        state_next = dstat.full ? ST_OUT : ST_INS_RD;
                    end
                    else
                    begin
                        state_next = dstat.empty ? ST_OUT : ST_REM_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = dstat.idx_zero ? ST_OUT : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = dstat.prio_gt ? ST_INS_RD : ST_OUT;
            end
            ST_REM_RD:
            begin
                state_next = dstat.empty ? ST_OUT : ST_REM_LD;
            end
            ST_REM_LD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        dcmd     = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                dcmd.accept = in_valid;
            end
            ST_INS_RD:
            begin
                dcmd.ins_wr  = dstat.idx_zero;
                dcmd.rd_prev = !dstat.idx_zero;
            end
            ST_INS_CMP:
            begin
                dcmd.shift_wr = dstat.prio_gt;
                dcmd.ins_wr   = !dstat.prio_gt;
            end
            ST_REM_RD:
            begin
                dcmd.rd_head = !dstat.empty;
            end
            ST_REM_LD:
            begin
                dcmd.head_ld = 1'b1;
            end
            ST_OUT:
            begin
                dcmd.out_ld = out_free;
            end
            default:
            begin
                dcmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dcmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/sorted_priority_queue_unit.sv @@
// Sorted priority queue, top level: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Holds up to DEPTH entries (data word and signed priority) in ascending
// priority order in a single-port-per-side circular memory; lower numbers
// leave first and equal priorities leave in arrival order. One item is in
// work at a time and gives one result. A remove that leaves entries behind
// reads the new head from memory and loads the head copy before its result;
// a rejected insert or remove goes straight to its result. An insert walks
// back from the tail one entry at a time (memory read, then compare and
// write) until its slot is found. The result register lets the next item
// be accepted while a result still waits to be taken.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic signed [31:0]                  data_in,
    input  logic signed [15:0]                  prio_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [31:0]                  removed_data,
    output logic signed [15:0]                  removed_prio,
    output logic signed [31:0]                  head_data,
    output logic signed [15:0]                  head_prio,
    output logic [$clog2(DEPTH + 1)-1:0]        occupancy,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int CW = $clog2(DEPTH + 1);

    dp_cmd_t       dcmd;
    dp_stat_t      dstat;
    status_t       res_status;
    entry_t        res_removed, res_head;
    logic [CW-1:0] res_count;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dstat     (dstat),
        .dcmd      (dcmd)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dcmd        (dcmd),
        .dstat       (dstat),
        .cmd         (cmd),
        .data_in     (data_in),
        .prio_in     (prio_in),
        .res_status  (res_status),
        .res_removed (res_removed),
        .res_head    (res_head),
        .res_count   (res_count)
    );

    assign status       = res_status;
    assign removed_data = $signed(res_removed.data);
    assign removed_prio = $signed(res_removed.prio);
    assign head_data    = $signed(res_head.data);
    assign head_prio    = $signed(res_head.prio);
    assign occupancy    = res_count;
    assign is_empty     = (res_count == '0);
    assign is_full      = (res_count == CW'(DEPTH));

    // Count never goes past DEPTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CW'(DEPTH)))
        else $error("occupancy above DEPTH");

    // A rejected insert only happens on a full queue
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_FULL) |-> is_full)
        else $error("full reject on non-full queue");

    // A failed remove reports nothing removed and an empty queue
    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_EMPTY) |->
        (is_empty && removed_data == '0 && removed_prio == '0))
        else $error("empty reject inconsistent");

    // Empty queue shows a zero head
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (head_data == '0 && head_prio == '0))
        else $error("nonzero head on empty queue");

    // No item is taken while the controller is busy with another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken during work");

endmodule
